// ===== sv/grid_spread_time_bfs_top_defines.svh =====
// Assertion helpers for the file that checks its own logic.
`ifndef GRID_SPREAD_TIME_BFS_TOP_DEFINES_SVH
`define GRID_SPREAD_TIME_BFS_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define GSTB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define GSTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/gstb_pkg.sv =====
`default_nettype none

package gstb_pkg;

  // Cell kinds as kept in the grid memory.
  localparam logic [1:0] KIND_UNFILLED = 2'b00;
  localparam logic [1:0] KIND_SEEDED   = 2'b01;
  localparam logic [1:0] KIND_EMPTY    = 2'b11;

  // Configuration register indexes.
  localparam int        CFG_IDX_W = 2;
  localparam int        CFG_W     = 7;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  localparam int        STEP_W    = 13;

  // Queue control from the sequencer.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } qctl_t;

endpackage

`default_nettype wire

// ===== sv/gstb_queue.sv =====
`default_nettype none

// Spread queue: one memory with head and tail pointers.
module gstb_queue import gstb_pkg::*; #(
  parameter int IDX_W = 12,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire qctl_t         ctl,
  input  wire logic [DW-1:0] wr_data,
  output logic      [DW-1:0] rd_data,
  output logic               empty
);

  localparam int DEPTH = 1 << IDX_W;

  logic [DW-1:0] mem [DEPTH];
  logic [IDX_W:0] head_r, head_nxt;
  logic [IDX_W:0] tail_r, tail_nxt;

  // Pointer updates.
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (ctl.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
    end else begin
      if (ctl.push) tail_nxt = tail_r + 1'b1;
      if (ctl.pop)  head_nxt = head_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  // Memory: write at the tail, registered read at the head.
  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.clear) mem[tail_r[IDX_W-1:0]] <= wr_data;
    if (ctl.pop) rd_data <= mem[head_r[IDX_W-1:0]];
  end

  assign empty = (head_r == tail_r);

endmodule

`default_nettype wire

// ===== sv/grid_spread_time_bfs_top.sv =====
// Channel | Direction | Ports
// in      | input     | in_valid, in_ready, in_cell_value, in_last_cell
// out     | output    | out_valid, out_ready, out_step_count
// cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// A cell word is taken whenever one is offered while the block is loading.
// After the last cell the block fills the tail of the grid, scans it for seeds, then
// pops each queued cell and checks its neighbors in range until it finds the queue
// empty; it then scans the grid again, checking for unfilled cells, and posts the
// result, all through the grid memory's one read port and one write port.
// Reset clears control and sets both shape registers to 64; the memories hold no reset contents.
// A pending result does not stall loading; a finished spread waits only for the result slot.
`default_nettype none

module grid_spread_time_bfs_top import gstb_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [1:0]    in_cell_value,
  input  wire logic                 in_last_cell,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [STEP_W-1:0]  out_step_count,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

`include "grid_spread_time_bfs_top_defines.svh"

  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int IDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W  = IDX_W + 1;
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int COL_W  = $clog2(MAX_COLS + 1);
  localparam int DIST_W = IDX_W;
  localparam int Q_W    = IDX_W + ROW_W + COL_W + DIST_W;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_FILL  = 4'd1;
  localparam logic [3:0] S_SEED  = 4'd2;
  localparam logic [3:0] S_POP   = 4'd3;
  localparam logic [3:0] S_POPW  = 4'd4;
  localparam logic [3:0] S_NBR   = 4'd5;
  localparam logic [3:0] S_NBRW  = 4'd6;
  localparam logic [3:0] S_CHECK = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DIST_W-1:0] lvl;
  } qent_t;

  // Configuration registers.
  logic [CFG_W-1:0] rows_cfg_r, cols_cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= CFG_W'(64);
      cols_cfg_r <= CFG_W'(64);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROWS: rows_cfg_r <= cfg_data;
        REG_COLS: cols_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective grid shape, clamped to the memory size.
  logic [ROW_W-1:0] rows_eff;
  logic [COL_W-1:0] cols_eff;
  logic [CNT_W-1:0] total_w;

  always_comb begin
    if (rows_cfg_r == '0) rows_eff = ROW_W'(1);
    else if (32'(rows_cfg_r) > 32'(MAX_ROWS)) rows_eff = ROW_W'(MAX_ROWS);
    else rows_eff = ROW_W'(rows_cfg_r);
    if (cols_cfg_r == '0) cols_eff = COL_W'(1);
    else if (32'(cols_cfg_r) > 32'(MAX_COLS)) cols_eff = COL_W'(MAX_COLS);
    else cols_eff = COL_W'(cols_cfg_r);
  end

  assign total_w = CNT_W'(rows_eff) * CNT_W'(cols_eff);

  // Sequencer registers.
  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [ROW_W-1:0]  rows_r, rows_nxt;
  logic [COL_W-1:0]  cols_r, cols_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [ROW_W-1:0]  srow_r, srow_nxt;
  logic [COL_W-1:0]  scol_r, scol_nxt;
  logic              pv_r, pv_nxt;
  logic [IDX_W-1:0]  pidx_r, pidx_nxt;
  logic [ROW_W-1:0]  prow_r, prow_nxt;
  logic [COL_W-1:0]  pcol_r, pcol_nxt;
  qent_t             cur_r, cur_nxt;
  qent_t             tgt_r, tgt_nxt;
  logic [1:0]        nb_r, nb_nxt;
  logic [DIST_W-1:0] max_r, max_nxt;
  logic              bad_r, bad_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // Grid memory port signals.
  logic             g_we;
  logic [IDX_W-1:0] g_wa;
  logic [1:0]       g_wd;
  logic [IDX_W-1:0] g_ra;
  logic [1:0]       grid_q;
  logic [1:0]       grid [CELLS];

  always_ff @(posedge clk) begin
    if (g_we) grid[g_wa] <= g_wd;
    grid_q <= grid[g_ra];
  end

  // Queue.
  qctl_t       qctl;
  qent_t       q_wr, q_rd;
  logic [Q_W-1:0] q_rd_vec;
  logic        q_empty;

  gstb_queue #(.IDX_W(IDX_W), .DW(Q_W)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (qctl),
    .wr_data (Q_W'(q_wr)),
    .rd_data (q_rd_vec),
    .empty   (q_empty)
  );

  assign q_rd = qent_t'(q_rd_vec);

  logic [1:0] in_kind;
  logic       in_acc;
  logic       scan_go;
  logic       nb_ok;
  qent_t      nb_ent;

  assign in_ready = (state_r == S_LOAD);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    case (in_cell_value)
      2'sb00:  in_kind = KIND_UNFILLED;
      2'sb01:  in_kind = KIND_SEEDED;
      default: in_kind = KIND_EMPTY;
    endcase
  end

  // Neighbor of the current cell: up, left, down, right.
  always_comb begin
    nb_ent     = cur_r;
    nb_ent.lvl = cur_r.lvl + 1'b1;
    nb_ok      = 1'b0;
    case (nb_r)
      2'd0: begin
        nb_ok      = (cur_r.row != '0);
        nb_ent.idx = cur_r.idx - IDX_W'(cols_r);
        nb_ent.row = cur_r.row - 1'b1;
      end
      2'd1: begin
        nb_ok      = (cur_r.col != '0);
        nb_ent.idx = cur_r.idx - 1'b1;
        nb_ent.col = cur_r.col - 1'b1;
      end
      2'd2: begin
        nb_ok      = ((ROW_W + 1)'(cur_r.row) + 1'b1) < (ROW_W + 1)'(rows_r);
        nb_ent.idx = cur_r.idx + IDX_W'(cols_r);
        nb_ent.row = cur_r.row + 1'b1;
      end
      default: begin
        nb_ok      = ((COL_W + 1)'(cur_r.col) + 1'b1) < (COL_W + 1)'(cols_r);
        nb_ent.idx = cur_r.idx + 1'b1;
        nb_ent.col = cur_r.col + 1'b1;
      end
    endcase
  end

  // Main sequencer.
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    total_nxt     = total_r;
    srow_nxt      = srow_r;
    scol_nxt      = scol_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    prow_nxt      = prow_r;
    pcol_nxt      = pcol_r;
    cur_nxt       = cur_r;
    tgt_nxt       = tgt_r;
    nb_nxt        = nb_r;
    max_nxt       = max_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && !out_ready;
    step_nxt      = step_r;
    g_we          = 1'b0;
    g_wa          = pos_r[IDX_W-1:0];
    g_wd          = KIND_EMPTY;
    g_ra          = pos_r[IDX_W-1:0];
    qctl          = '0;
    q_wr          = '0;
    scan_go       = (pos_r < total_r);

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (pos_r < total_w) begin
            g_we    = 1'b1;
            g_wd    = in_kind;
            pos_nxt = pos_r + 1'b1;
          end
          if (in_last_cell) begin
            rows_nxt   = rows_eff;
            cols_nxt   = cols_eff;
            total_nxt  = total_w;
            qctl.clear = 1'b1;
            max_nxt    = '0;
            state_nxt  = S_FILL;
          end
        end
      end
      S_FILL: begin
        // Cells never loaded count as empty.
        if (pos_r < total_r) begin
          g_we    = 1'b1;
          pos_nxt = pos_r + 1'b1;
        end else begin
          pos_nxt   = '0;
          srow_nxt  = '0;
          scol_nxt  = '0;
          state_nxt = S_SEED;
        end
      end
      S_SEED, S_CHECK: begin
        // Pipelined scan: address now, cell kind in the next cycle.
        if (scan_go) begin
          pv_nxt   = 1'b1;
          pidx_nxt = pos_r[IDX_W-1:0];
          prow_nxt = srow_r;
          pcol_nxt = scol_r;
          pos_nxt  = pos_r + 1'b1;
          if ((COL_W + 1)'(scol_r) + 1'b1 == (COL_W + 1)'(cols_r)) begin
            scol_nxt = '0;
            srow_nxt = srow_r + 1'b1;
          end else begin
            scol_nxt = scol_r + 1'b1;
          end
        end
        if (pv_r) begin
          if (state_r == S_SEED && grid_q == KIND_SEEDED) begin
            qctl.push = 1'b1;
            q_wr.idx  = pidx_r;
            q_wr.row  = prow_r;
            q_wr.col  = pcol_r;
            q_wr.lvl  = '0;
          end
          if (state_r == S_CHECK && grid_q == KIND_UNFILLED) bad_nxt = 1'b1;
        end
        if (!scan_go && !pv_r) begin
          state_nxt = (state_r == S_SEED) ? S_POP : S_DONE;
        end
      end
      S_POP: begin
        if (q_empty) begin
          pos_nxt   = '0;
          srow_nxt  = '0;
          scol_nxt  = '0;
          bad_nxt   = 1'b0;
          state_nxt = S_CHECK;
        end else begin
          qctl.pop  = 1'b1;
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        cur_nxt = q_rd;
        if (q_rd.lvl > max_r) max_nxt = q_rd.lvl;
        nb_nxt    = '0;
        state_nxt = S_NBR;
      end
      S_NBR: begin
        if (nb_ok) begin
          g_ra      = nb_ent.idx;
          tgt_nxt   = nb_ent;
          state_nxt = S_NBRW;
        end else if (nb_r == 2'd3) begin
          state_nxt = S_POP;
        end else begin
          nb_nxt = nb_r + 1'b1;
        end
      end
      S_NBRW: begin
        // Claim an unfilled neighbor and queue it one step further.
        if (grid_q == KIND_UNFILLED) begin
          g_we      = 1'b1;
          g_wa      = tgt_r.idx;
          g_wd      = KIND_SEEDED;
          qctl.push = 1'b1;
          q_wr      = tgt_r;
        end
        if (nb_r == 2'd3) begin
          state_nxt = S_POP;
        end else begin
          nb_nxt    = nb_r + 1'b1;
          state_nxt = S_NBR;
        end
      end
      S_DONE: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          step_nxt      = bad_r ? {STEP_W{1'b1}} : STEP_W'(max_r);
          pos_nxt       = '0;
          state_nxt     = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      pos_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      max_r       <= '0;
      bad_r       <= 1'b0;
      nb_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
      max_r       <= max_nxt;
      bad_r       <= bad_nxt;
      nb_r        <= nb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rows_r  <= rows_nxt;
    cols_r  <= cols_nxt;
    total_r <= total_nxt;
    srow_r  <= srow_nxt;
    scol_r  <= scol_nxt;
    pidx_r  <= pidx_nxt;
    prow_r  <= prow_nxt;
    pcol_r  <= pcol_nxt;
    cur_r   <= cur_nxt;
    tgt_r   <= tgt_nxt;
    step_r  <= step_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_step_count = step_r;

  // Checks on the sequencer.
  `GSTB_ASSERT_NEXT(a_last_starts_fill, in_acc && in_last_cell, state_r == S_FILL, "last cell did not start the fill")
  `GSTB_ASSERT_NOW(a_claim_unfilled, state_r == S_NBRW && g_we, grid_q == KIND_UNFILLED, "claimed a cell that was not unfilled")
  `GSTB_ASSERT_NEXT(a_done_posts, state_r == S_DONE && !out_valid_r, out_valid_r && state_r == S_LOAD, "result not posted")

endmodule

`default_nettype wire

// ===== tb/sv/grid_spread_time_bfs_checker.sv =====
`default_nettype none

module grid_spread_time_bfs_checker import gstb_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire logic signed [1:0]    in_cell_value,
  input  wire logic                 in_last_cell,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire logic signed [STEP_W-1:0] out_step_count,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output int                        fail_count,
  output int                        pending_steps
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_MAX = 64;
  localparam int CELL_MAX = GRID_MAX * GRID_MAX;

  // Shadow copy of the block's registers and grid.
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  logic [1:0]       kind_mem [CELL_MAX];
  int               bfs_cell [CELL_MAX];
  int               bfs_dist [CELL_MAX];
  int               loaded;
  logic [STEP_W-1:0] step_queue [$];

  function automatic int clamp_dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > GRID_MAX) return GRID_MAX;
    return int'(v);
  endfunction

  // Marks an unfilled neighbor as filled and queues it.
  function automatic void fill_cell(int idx, int d, ref int tail);
    if (kind_mem[idx] == KIND_UNFILLED) begin
      kind_mem[idx] = KIND_SEEDED;
      bfs_cell[tail] = idx;
      bfs_dist[tail] = d;
      tail++;
    end
  endfunction

  // Multi-source spread over the loaded grid; returns the fill time, or all ones if a cell stays unfilled.
  function automatic logic [STEP_W-1:0] spread_time(int rows, int cols);
    int total;
    int head;
    int tail;
    int far;
    int v;
    int d;
    int r;
    int c;
    total = rows * cols;
    head = 0;
    tail = 0;
    far = 0;
    for (int i = loaded; i < total; i++) kind_mem[i] = KIND_EMPTY;
    for (int i = 0; i < total; i++) begin
      if (kind_mem[i] == KIND_SEEDED) begin
        bfs_cell[tail] = i;
        bfs_dist[tail] = 0;
        tail++;
      end
    end
    while (head < tail) begin
      v = bfs_cell[head];
      d = bfs_dist[head];
      r = v / cols;
      c = v % cols;
      head++;
      if (d > far) far = d;
      if (r > 0) fill_cell(v - cols, d + 1, tail);
      if (c > 0) fill_cell(v - 1, d + 1, tail);
      if (r + 1 < rows) fill_cell(v + cols, d + 1, tail);
      if (c + 1 < cols) fill_cell(v + 1, d + 1, tail);
    end
    for (int i = 0; i < total; i++) begin
      if (kind_mem[i] == KIND_UNFILLED) return '1;
    end
    return far[STEP_W-1:0];
  endfunction

  assign pending_steps = step_queue.size();

  always @(posedge clk) begin
    int total;
    logic [STEP_W-1:0] want;
    if (!rst_n) begin
      rows_reg <= 7'd64;
      cols_reg <= 7'd64;
      loaded = 0;
      fail_count <= 0;
      step_queue.delete();
    end else begin
      // Register writes.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ROWS) rows_reg <= cfg_data;
        else if (cfg_index == REG_COLS) cols_reg <= cfg_data;
      end
      // Cell words: load, and spread on the last one.
      if (in_valid && in_ready) begin
        total = clamp_dim(rows_reg) * clamp_dim(cols_reg);
        if (loaded < total) begin
          if (in_cell_value == 2'sd0) kind_mem[loaded] = KIND_UNFILLED;
          else if (in_cell_value == 2'sd1) kind_mem[loaded] = KIND_SEEDED;
          else kind_mem[loaded] = KIND_EMPTY;
          loaded++;
        end
        if (in_last_cell) begin
          step_queue.push_back(spread_time(clamp_dim(rows_reg), clamp_dim(cols_reg)));
          loaded = 0;
        end
      end
      // Result words against the oldest expectation.
      if (out_valid && out_ready) begin
        if (step_queue.size() == 0) begin
          $display("%0t: unexpected result word, actual step_count %0d", $time,
                   out_step_count);
          fail_count <= fail_count + 1;
        end else begin
          want = step_queue.pop_front();
          if (out_step_count !== want) begin
            $display("%0t: step_count mismatch, expected %0d, actual %0d", $time,
                     $signed(want), out_step_count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_grid_spread_time_bfs_top.sv =====
`default_nettype none

module tb_grid_spread_time_bfs_top import gstb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_CELLS = 1150;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [1:0]     in_cell_value = '0;
  logic                  in_last_cell = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [STEP_W-1:0] out_step_count;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  int                    fail_count;
  int                    pending_steps;

  // Shared stimulus state: phase of idling and the current grid shape.
  int send_idle_pct = 13;
  int recv_idle_pct = 46;
  int cells_sent = 0;
  int grid_rows = 64;
  int grid_cols = 64;
  int cycles = 0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  always #6 clk = ~clk;

  grid_spread_time_bfs_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cell_value(in_cell_value), .in_last_cell(in_last_cell),
    .out_valid(out_valid), .out_ready(out_ready), .out_step_count(out_step_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  grid_spread_time_bfs_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cell_value(in_cell_value), .in_last_cell(in_last_cell),
    .out_valid(out_valid), .out_ready(out_ready), .out_step_count(out_step_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_steps(pending_steps)
  );

  // Runaway guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && cells_sent >= 300) begin
      out_ready <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= 4000;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic int eff_dim(int v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  // Sends one cell word, with random idle cycles ahead of it.
  task automatic send_cell(logic signed [1:0] value, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cell_value <= value;
    in_last_cell <= last;
    do @(posedge clk); while (!in_ready);
    cells_sent++;
    @(negedge clk);
  endtask

  // Waits until every result is back and the block has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_steps != 0);
    repeat (20 * eff_dim(grid_rows) * eff_dim(grid_cols) + 200) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_ROWS) grid_rows = value;
    else if (idx == REG_COLS) grid_cols = value;
  endtask

  task automatic set_shape(int rows, int cols);
    wait_idle();
    write_reg(REG_ROWS, rows[CFG_W-1:0]);
    write_reg(REG_COLS, cols[CFG_W-1:0]);
  endtask

  function automatic logic signed [1:0] rand_cell();
    int p;
    p = $urandom_range(99);
    if (p < 15) return 2'sd1;
    if (p < 40) return -2'sd1;
    if (p < 45) return -2'sd2;
    return 2'sd0;
  endfunction

  function automatic int rand_dim();
    int p;
    p = $urandom_range(99);
    if (p < 5) return 0;
    if (p < 8) return $urandom_range(127, 65);
    if (p < 12) return 1;
    return $urandom_range(8, 1);
  endfunction

  initial begin
    int total;
    int count;
    int mode;
    int rows;
    int cols;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset shape, grid ended early with every cell kind.
    send_idle_pct = 0;
    send_cell(2'sd1, 1'b0);
    send_cell(2'sd0, 1'b0);
    send_cell(-2'sd1, 1'b0);
    send_cell(-2'sd2, 1'b0);
    send_cell(2'sd0, 1'b1);

    // Every cell seeded, then nothing seeded at all.
    set_shape(2, 2);
    repeat (3) send_cell(2'sd1, 1'b0);
    send_cell(2'sd1, 1'b1);
    send_cell(2'sd0, 1'b0);
    send_cell(-2'sd1, 1'b0);
    send_cell(-2'sd1, 1'b0);
    send_cell(2'sd0, 1'b1);

    // Too many cells for the shape.
    send_cell(2'sd0, 1'b0);
    send_cell(2'sd1, 1'b0);
    send_cell(2'sd0, 1'b0);
    send_cell(2'sd0, 1'b0);
    send_cell(2'sd1, 1'b0);
    send_cell(2'sd0, 1'b1);

    // Out-of-range registers: zero acts as one, large values as the maximum.
    set_shape(0, 127);
    write_reg(2'd3, 7'h55);
    send_cell(2'sd1, 1'b0);
    send_cell(2'sd0, 1'b0);
    send_cell(2'sd0, 1'b1);
    set_shape(127, 0);
    send_cell(2'sd0, 1'b0);
    send_cell(-2'sd1, 1'b0);
    send_cell(2'sd1, 1'b1);

    // Random grids through three idling phases.
    send_idle_pct = 13;
    while (cells_sent < RANDOM_CELLS + 30) begin
      if (cells_sent >= 430 && cells_sent < 830) begin
        send_idle_pct = 46;
        recv_idle_pct = 13;
      end else if (cells_sent >= 830) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if ($urandom_range(2) == 0) begin
        rows = rand_dim();
        cols = rand_dim();
        if (eff_dim(rows) * eff_dim(cols) > 160) cols = $urandom_range(2, 1);
        set_shape(rows, cols);
      end
      total = eff_dim(grid_rows) * eff_dim(grid_cols);
      mode = $urandom_range(9);
      if (mode == 0) count = $urandom_range(total, 1);
      else if (mode == 1) count = total + $urandom_range(4, 1);
      else count = total;
      for (int i = 0; i < count; i++) send_cell(rand_cell(), i == count - 1);
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_steps != 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== grid_spread_time_bfs_top.f =====
+incdir+sv
sv/gstb_pkg.sv
sv/gstb_queue.sv
sv/grid_spread_time_bfs_top.sv
tb/sv/grid_spread_time_bfs_checker.sv
tb/sv/tb_grid_spread_time_bfs_top.sv
